@@ hw/rtl/dma_transfer_slot_queue_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef DMA_TRANSFER_SLOT_QUEUE_MACROS_SVH
`define DMA_TRANSFER_SLOT_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every edge outside reset.
`define DTSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dtsq assertion failed");
// Expression must never be true outside reset.
`define DTSQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dtsq forbidden condition seen");
`else
`define DTSQ_ASSERT(lbl, clk, rst_n, prop)
`define DTSQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ hw/rtl/dtsq_pkg.sv @@
package dtsq_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_ENQUEUE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_FLUSH   = 2'd3
    } t_action;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_DESC  = 2'd2;

    // Most descriptors one flush beat sequence may carry
    localparam int MAX_OUT    = 32;
    localparam int CNT_W      = 6;
    localparam int TILE_SHIFT = 5;

    typedef struct packed {
        t_action      action;
        logic [15:0]  slot_number;
        logic [31:0]  source_address;
        logic [31:0]  target_address;
        logic [7:0]   tile_count;
    } t_in;

    typedef struct packed {
        logic [1:0]   result_kind;
        logic [4:0]   found_slot;
        logic         slot_valid;
        logic [31:0]  copy_source;
        logic [31:0]  copy_target;
        logic [12:0]  byte_length;
        logic         last;
    } t_out;

    typedef struct packed {
        logic [31:0]  src;
        logic [31:0]  tgt;
        logic [7:0]   tiles;
    } t_slot_entry;

endpackage

@@ hw/rtl/dtsq_scan.sv @@
`include "dma_transfer_slot_queue_macros.svh"

module dtsq_scan
    import dtsq_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    input  logic i_push_ok,
    output logic o_push,
    output t_out o_res
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_ALLOC,
        ST_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SLOTS-1:0]    r_pend, n_pend;
    logic                r_hold_v, n_hold_v;
    logic [SW-1:0]       r_hold_slot, n_hold_slot;

    t_slot_entry         r_mem [SLOTS];
    t_slot_entry         r_rd;

    logic                w_accept;
    logic [SW-1:0]       w_sidx;
    logic                w_end;
    logic                w_hit;
    logic                w_wr_en;
    logic                w_rd_en;
    t_out                w_desc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_sidx     = r_idx[SW-1:0];
    assign w_end      = (r_idx == CW'(SLOTS)) || (r_cnt == CNT_W'(MAX_OUT));
    assign w_hit      = r_pend[w_sidx];

    // Held descriptor: read data of the last flushed slot
    always_comb begin
        w_desc             = '0;
        w_desc.result_kind = KIND_DESC;
        w_desc.found_slot  = 5'(r_hold_slot);
        w_desc.copy_source = r_rd.src;
        w_desc.copy_target = r_rd.tgt;
        w_desc.byte_length = {r_rd.tiles, {TILE_SHIFT{1'b0}}};
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_hold_v    = r_hold_v;
        n_hold_slot = r_hold_slot;
        o_push      = 1'b0;
        o_res       = '0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        ACT_ALLOC: begin
                            n_idx   = '0;
                            n_state = ST_ALLOC;
                        end
                        ACT_ENQUEUE: begin
                            if (i_in.slot_number < 16'(SLOTS)) begin
                                w_wr_en = 1'b1;
                                n_pend[i_in.slot_number[SW-1:0]] = (i_in.tile_count != 8'd0);
                            end
                            n_state = ST_ACK;
                        end
                        ACT_CLEAR: begin
                            n_pend  = '0;
                            n_state = ST_ACK;
                        end
                        default: begin
                            n_idx    = '0;
                            n_cnt    = '0;
                            n_hold_v = 1'b0;
                            n_state  = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_ACK: begin
                o_res.result_kind = KIND_ACK;
                o_res.last        = 1'b1;
                o_push            = i_push_ok;
                if (i_push_ok) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ALLOC: begin
                if (!w_hit) begin
                    o_res.result_kind = KIND_ALLOC;
                    o_res.found_slot  = 5'(w_sidx);
                    o_res.slot_valid  = 1'b1;
                    o_res.last        = 1'b1;
                    o_push            = i_push_ok;
                    if (i_push_ok) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_idx == CW'(SLOTS - 1)) begin
                    // every slot busy
                    o_res.result_kind = KIND_ALLOC;
                    o_res.last        = 1'b1;
                    o_push            = i_push_ok;
                    if (i_push_ok) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_FLUSH: begin
                if (w_end) begin
                    if (r_hold_v) begin
                        o_res      = w_desc;
                        o_res.last = 1'b1;
                    end else begin
                        o_res.result_kind = KIND_ACK;
                        o_res.last        = 1'b1;
                    end
                    o_push = i_push_ok;
                    if (i_push_ok) begin
                        n_hold_v = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end else if (w_hit) begin
                    if (r_hold_v) begin
                        // another pending slot follows, so the held one is not last
                        o_res  = w_desc;
                        o_push = i_push_ok;
                        if (i_push_ok) begin
                            n_hold_v = 1'b0;
                        end
                    end else begin
                        w_rd_en        = 1'b1;
                        n_pend[w_sidx] = 1'b0;
                        n_hold_slot    = w_sidx;
                        n_hold_v       = 1'b1;
                        n_cnt          = r_cnt + CNT_W'(1);
                        n_idx          = r_idx + CW'(1);
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_pend      <= '0;
            r_hold_v    <= 1'b0;
            r_hold_slot <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_hold_v    <= n_hold_v;
            r_hold_slot <= n_hold_slot;
        end
    end

    // Slot store: addresses and counts, single write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_in.slot_number[SW-1:0]] <= '{i_in.source_address,
                                                 i_in.target_address,
                                                 i_in.tile_count};
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_sidx];
        end
    end

    `DTSQ_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_OUT))
    `DTSQ_ASSERT(a_desc_freed, i_clk, i_rst_n, (o_push && o_res.result_kind == KIND_DESC) |-> !r_pend[r_hold_slot])
    `DTSQ_ASSERT(a_clear_all, i_clk, i_rst_n, (w_accept && i_in.action == ACT_CLEAR) |=> (r_pend == '0))
    `DTSQ_ASSERT_NEVER(a_ready_hold, i_clk, i_rst_n, o_in_ready && r_hold_v)

endmodule

@@ hw/rtl/dma_transfer_slot_queue.sv @@
// Enqueue and clear answer with an ack from the ACK state once the output register can take it;
//   alloc scans up from slot 0 and answers with the lowest free slot, or no valid slot if all are busy.
// Flush: walks the slots, holding each pending descriptor until the next one is found, then closes
//   with the held descriptor marked last, or with an ack when nothing is pending.
// Throughput: one item at a time; the next beat is taken the cycle after its last result.
// Reset: pending flags and control cleared; slot addresses and counts are not reset.
module dma_transfer_slot_queue
    import dtsq_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic r_out_valid;
    t_out r_out;
    logic w_push_ok;
    logic w_push;
    t_out w_res;

    assign w_push_ok = !r_out_valid || i_out_ready;

    dtsq_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in_data),
        .i_push_ok  (w_push_ok),
        .o_push     (w_push),
        .o_res      (w_res)
    );

    // Output register: holds a result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
